/* rtl/linear_equation_text_solver_assert.svh */
// Assertion macros for the checker files of the equation solver.
`ifndef LINEAR_EQUATION_TEXT_SOLVER_ASSERT_SVH
`define LINEAR_EQUATION_TEXT_SOLVER_ASSERT_SVH

// Check a property at every clock edge outside reset.
`define LETSV_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Check a property at every clock edge, reset included.
`define LETSV_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

/* rtl/letsv_pkg.sv */
// Shared types and constants of the linear equation text solver.
package letsv_pkg;

   localparam int unsigned SUM_W      = 32;
   localparam int unsigned LETTER_W   = 5;
   localparam int unsigned RSP_DATA_W = 136;

   // token kinds produced by the character classifier
   localparam logic [2:0] TOK_DIGIT  = 3'd0;
   localparam logic [2:0] TOK_LETTER = 3'd1;
   localparam logic [2:0] TOK_DELIM  = 3'd2;
   localparam logic [2:0] TOK_EQUAL  = 3'd3;
   localparam logic [2:0] TOK_MINUS  = 3'd4;
   localparam logic [2:0] TOK_SPACE  = 3'd5;
   localparam logic [2:0] TOK_IGNORE = 3'd6;

   // result status codes
   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_SEVERAL   = 2'd1;
   localparam logic [1:0] STATUS_NO_VAR    = 2'd2;
   localparam logic [1:0] STATUS_ZERO_COEF = 2'd3;

   typedef struct packed {
      logic [2:0]          kind;
      logic [LETTER_W-1:0] value;
      logic                last;
   } char_tok_type;

   typedef struct packed {
      logic [SUM_W-1:0]    coef;
      logic [SUM_W-1:0]    konst;
      logic                several;
      logic                seen;
      logic [LETTER_W-1:0] letter;
   } job_type;

endpackage

/* rtl/letsv_front.sv */
// Input beat acceptance and character classification into tokens.
module letsv_front (
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [7:0]              req_tdata,
   input  logic                    req_tlast,
   input  logic                    queue_full,
   output logic                    push,
   output letsv_pkg::char_tok_type push_tok
);

   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_SP    = 8'h20;
   localparam logic [7:0] CH_PCT   = 8'h25;
   localparam logic [7:0] CH_LPAR  = 8'h28;
   localparam logic [7:0] CH_RPAR  = 8'h29;
   localparam logic [7:0] CH_STAR  = 8'h2A;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_0     = 8'h30;
   localparam logic [7:0] CH_9     = 8'h39;
   localparam logic [7:0] CH_EQ    = 8'h3D;
   localparam logic [7:0] CH_UA    = 8'h41;
   localparam logic [7:0] CH_UZ    = 8'h5A;
   localparam logic [7:0] CH_CARET = 8'h5E;
   localparam logic [7:0] CH_LA    = 8'h61;
   localparam logic [7:0] CH_LZ    = 8'h7A;

   logic [7:0] c;

   assign c = req_tdata;

   always_comb begin
      push_tok.kind  = letsv_pkg::TOK_IGNORE;
      push_tok.value = '0;
      push_tok.last  = req_tlast;
      case (c)
         CH_EQ:    push_tok.kind = letsv_pkg::TOK_EQUAL;
         CH_MINUS: push_tok.kind = letsv_pkg::TOK_MINUS;
         CH_PLUS, CH_STAR, CH_SLASH, CH_PCT, CH_CARET, CH_LPAR, CH_RPAR:
            push_tok.kind = letsv_pkg::TOK_DELIM;
         default: begin
            if (c >= CH_0 && c <= CH_9) begin
               push_tok.kind  = letsv_pkg::TOK_DIGIT;
               push_tok.value = 5'(c - CH_0);
            end else if (c >= CH_LA && c <= CH_LZ) begin
               push_tok.kind  = letsv_pkg::TOK_LETTER;
               push_tok.value = 5'(c - CH_LA);
            end else if (c >= CH_UA && c <= CH_UZ) begin
               push_tok.kind  = letsv_pkg::TOK_LETTER;
               push_tok.value = 5'(c - CH_UA);
            end else if (c == CH_NUL || c == CH_SP || (c >= CH_TAB && c <= CH_CR)) begin
               push_tok.kind = letsv_pkg::TOK_SPACE;
            end
         end
      endcase
   end

   assign req_tready = !queue_full;
   // drop unknown characters unless they close the equation
   assign push = req_tvalid && req_tready &&
                 (push_tok.kind != letsv_pkg::TOK_IGNORE || req_tlast);

endmodule

/* rtl/letsv_fifo.sv */
// Short token queue between the classifier and the accumulator.
module letsv_fifo #(
   parameter int unsigned DEPTH = 4
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  letsv_pkg::char_tok_type push_tok,
   output logic                    full,
   input  logic                    pop,
   output logic                    pop_valid,
   output letsv_pkg::char_tok_type pop_tok
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   letsv_pkg::char_tok_type entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ff, wr_in;
   logic [PTR_W-1:0] rd_ff, rd_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             do_push, do_pop;

   assign full      = (cnt_ff == CNT_W'(DEPTH));
   assign pop_valid = (cnt_ff != '0);
   assign pop_tok   = entry_ff[rd_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && pop_valid;

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (do_push) begin
         wr_in = (wr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_in = (rd_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ff] <= push_tok;
      end
   end

endmodule

/* rtl/letsv_back.sv */
// Token accumulator: builds numbers and sums coefficients and constants.
module letsv_back #(
   parameter int unsigned NUMBER_WIDTH = 32
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    tok_valid,
   input  letsv_pkg::char_tok_type tok,
   output logic                    pop,
   output logic                    job_valid,
   output letsv_pkg::job_type      job,
   input  logic                    job_ready
);

   localparam logic [1:0] B_RUN  = 2'd0;
   localparam logic [1:0] B_FIN  = 2'd1;
   localparam logic [1:0] B_HAND = 2'd2;

   logic [1:0]              state_ff, state_in;
   logic                    run_ff, run_in;
   logic [NUMBER_WIDTH-1:0] num_ff, num_in;
   logic                    after_ff, after_in;
   logic                    minus_ff, minus_in;
   logic [4:0]              letter_ff, letter_in;
   logic                    seen_ff, seen_in;
   logic                    several_ff, several_in;
   logic [31:0]             coef_ff, coef_in;
   logic [31:0]             konst_ff, konst_in;

   logic [31:0] num_val, lead_val, konst_term, coef_term;

   assign pop = tok_valid && (state_ff == B_RUN);

   always_comb begin
      num_val    = 32'($signed(num_ff));
      konst_term = after_ff ? num_val : -num_val;
      if (minus_ff) begin
         konst_term = -konst_term;
      end
      lead_val  = (num_ff == '0) ? 32'd1 : num_val;
      coef_term = after_ff ? -lead_val : lead_val;
      if (minus_ff) begin
         coef_term = -coef_term;
      end
   end

   always_comb begin
      state_in   = state_ff;
      run_in     = run_ff;
      num_in     = num_ff;
      after_in   = after_ff;
      minus_in   = minus_ff;
      letter_in  = letter_ff;
      seen_in    = seen_ff;
      several_in = several_ff;
      coef_in    = coef_ff;
      konst_in   = konst_ff;
      case (state_ff)
         B_RUN: begin
            if (pop) begin
               case (tok.kind)
                  letsv_pkg::TOK_DIGIT: begin
                     if (run_ff) begin
                        num_in = (num_ff << 3) + (num_ff << 1) + NUMBER_WIDTH'(tok.value);
                     end else begin
                        num_in = NUMBER_WIDTH'(tok.value);
                     end
                     run_in = 1'b1;
                  end
                  letsv_pkg::TOK_LETTER: begin
                     coef_in  = coef_ff + coef_term;
                     minus_in = 1'b0;
                     if (seen_ff && letter_ff != tok.value) begin
                        several_in = 1'b1;
                     end
                     if (!seen_ff) begin
                        letter_in = tok.value;
                        seen_in   = 1'b1;
                     end
                     num_in = '0;
                     run_in = 1'b0;
                  end
                  letsv_pkg::TOK_DELIM, letsv_pkg::TOK_EQUAL, letsv_pkg::TOK_MINUS: begin
                     if (num_ff != '0) begin
                        konst_in = konst_ff + konst_term;
                        minus_in = 1'b0;
                     end
                     num_in = '0;
                     run_in = 1'b0;
                     if (tok.kind == letsv_pkg::TOK_EQUAL) begin
                        after_in = 1'b1;
                     end
                     if (tok.kind == letsv_pkg::TOK_MINUS) begin
                        minus_in = 1'b1;
                     end
                  end
                  letsv_pkg::TOK_SPACE: run_in = 1'b0;
                  default: ;
               endcase
               if (tok.last) begin
                  state_in = B_FIN;
               end
            end
         end
         B_FIN: begin
            // commit a number still open at the end of the text
            if (num_ff != '0) begin
               konst_in = konst_ff + konst_term;
            end
            state_in = B_HAND;
         end
         B_HAND: begin
            if (job_ready) begin
               state_in   = B_RUN;
               run_in     = 1'b0;
               num_in     = '0;
               after_in   = 1'b0;
               minus_in   = 1'b0;
               letter_in  = '0;
               seen_in    = 1'b0;
               several_in = 1'b0;
               coef_in    = '0;
               konst_in   = '0;
            end
         end
         default: state_in = B_RUN;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= B_RUN;
         run_ff     <= 1'b0;
         num_ff     <= '0;
         after_ff   <= 1'b0;
         minus_ff   <= 1'b0;
         letter_ff  <= '0;
         seen_ff    <= 1'b0;
         several_ff <= 1'b0;
         coef_ff    <= '0;
         konst_ff   <= '0;
      end else begin
         state_ff   <= state_in;
         run_ff     <= run_in;
         num_ff     <= num_in;
         after_ff   <= after_in;
         minus_ff   <= minus_in;
         letter_ff  <= letter_in;
         seen_ff    <= seen_in;
         several_ff <= several_in;
         coef_ff    <= coef_in;
         konst_ff   <= konst_in;
      end
   end

   assign job_valid   = (state_ff == B_HAND);
   assign job.coef    = coef_ff;
   assign job.konst   = konst_ff;
   assign job.several = several_ff;
   assign job.seen    = seen_ff;
   assign job.letter  = letter_ff;

endmodule

/* rtl/letsv_solve.sv */
// Result unit: status, binary gcd and two shift-subtract divisions.
module letsv_solve (
   input  logic               clock,
   input  logic               reset,
   input  logic               job_valid,
   input  letsv_pkg::job_type job,
   output logic               job_ready,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [1:0]         status,
   output logic [4:0]         letter,
   output logic               is_negative,
   output logic [31:0]        numerator,
   output logic [31:0]        denominator,
   output logic [31:0]        coef_total,
   output logic [31:0]        konst_total
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_GCD  = 3'd1;
   localparam logic [2:0] S_DIVN = 3'd2;
   localparam logic [2:0] S_DIVD = 3'd3;
   localparam logic [2:0] S_OUT  = 3'd4;

   logic [2:0]  state_ff, state_in;
   logic [1:0]  status_ff, status_in;
   logic [4:0]  letter_ff, letter_in;
   logic        neg_ff, neg_in;
   logic [31:0] numer_ff, numer_in;
   logic [31:0] denom_ff, denom_in;
   logic [31:0] coef_ff, coef_in;
   logic [31:0] konst_ff, konst_in;
   logic [31:0] ca_ff, ca_in;
   logic [31:0] va_ff, va_in;
   logic [31:0] a_ff, a_in;
   logic [31:0] b_ff, b_in;
   logic [4:0]  k_ff, k_in;
   logic [31:0] g_ff, g_in;
   logic [31:0] rem_ff, rem_in;
   logic [31:0] quo_ff, quo_in;
   logic [4:0]  cnt_ff, cnt_in;

   logic [32:0] rem_sh, rem_diff;
   logic        rem_ge;

   // one restoring division step
   assign rem_sh   = {rem_ff, quo_ff[31]};
   assign rem_diff = rem_sh - {1'b0, g_ff};
   assign rem_ge   = (rem_sh >= {1'b0, g_ff});

   always_comb begin
      state_in  = state_ff;
      status_in = status_ff;
      letter_in = letter_ff;
      neg_in    = neg_ff;
      numer_in  = numer_ff;
      denom_in  = denom_ff;
      coef_in   = coef_ff;
      konst_in  = konst_ff;
      ca_in     = ca_ff;
      va_in     = va_ff;
      a_in      = a_ff;
      b_in      = b_ff;
      k_in      = k_ff;
      g_in      = g_ff;
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      cnt_in    = cnt_ff;
      case (state_ff)
         S_IDLE: begin
            if (job_valid) begin
               coef_in  = job.coef;
               konst_in = job.konst;
               neg_in   = 1'b0;
               numer_in = '0;
               denom_in = 32'd1;
               ca_in    = job.konst[31] ? -job.konst : job.konst;
               va_in    = job.coef[31] ? -job.coef : job.coef;
               a_in     = ca_in;
               b_in     = va_in;
               k_in     = '0;
               if (job.several) begin
                  status_in = letsv_pkg::STATUS_SEVERAL;
                  letter_in = '0;
                  state_in  = S_OUT;
               end else if (!job.seen) begin
                  status_in = letsv_pkg::STATUS_NO_VAR;
                  letter_in = '0;
                  state_in  = S_OUT;
               end else if (job.coef == '0) begin
                  status_in = letsv_pkg::STATUS_ZERO_COEF;
                  letter_in = job.letter;
                  state_in  = S_OUT;
               end else begin
                  status_in = letsv_pkg::STATUS_OK;
                  letter_in = job.letter;
                  neg_in    = job.konst[31] ^ job.coef[31];
                  state_in  = S_GCD;
               end
            end
         end
         S_GCD: begin
            if (a_ff == '0) begin
               g_in     = b_ff << k_ff;
               rem_in   = '0;
               quo_in   = ca_ff;
               cnt_in   = '0;
               state_in = S_DIVN;
            end else if (!a_ff[0] && !b_ff[0]) begin
               a_in = a_ff >> 1;
               b_in = b_ff >> 1;
               k_in = k_ff + 1'b1;
            end else if (!a_ff[0]) begin
               a_in = a_ff >> 1;
            end else if (!b_ff[0]) begin
               b_in = b_ff >> 1;
            end else if (a_ff >= b_ff) begin
               a_in = a_ff - b_ff;
            end else begin
               b_in = b_ff - a_ff;
            end
         end
         S_DIVN, S_DIVD: begin
            rem_in = rem_ge ? rem_diff[31:0] : rem_sh[31:0];
            quo_in = {quo_ff[30:0], rem_ge};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == 5'd31) begin
               if (state_ff == S_DIVN) begin
                  numer_in = quo_in;
                  rem_in   = '0;
                  quo_in   = va_ff;
                  cnt_in   = '0;
                  state_in = S_DIVD;
               end else begin
                  denom_in = quo_in;
                  state_in = S_OUT;
               end
            end
         end
         S_OUT: begin
            if (rsp_ready) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
      letter_ff <= letter_in;
      neg_ff    <= neg_in;
      numer_ff  <= numer_in;
      denom_ff  <= denom_in;
      coef_ff   <= coef_in;
      konst_ff  <= konst_in;
      ca_ff     <= ca_in;
      va_ff     <= va_in;
      a_ff      <= a_in;
      b_ff      <= b_in;
      k_ff      <= k_in;
      g_ff      <= g_in;
      rem_ff    <= rem_in;
      quo_ff    <= quo_in;
      cnt_ff    <= cnt_in;
   end

   assign job_ready   = (state_ff == S_IDLE);
   assign rsp_valid   = (state_ff == S_OUT);
   assign status      = status_ff;
   assign letter      = letter_ff;
   assign is_negative = neg_ff;
   assign numerator   = numer_ff;
   assign denominator = denom_ff;
   assign coef_total  = coef_ff;
   assign konst_total = konst_ff;

endmodule

/* rtl/linear_equation_text_solver.sv */
// Linear equation text solver: character stream in, one solution beat per equation out.
//
// Input channel req_*: one ASCII character per beat in req_tdata[7:0]; req_tlast marks
// the final character of an equation. Characters are taken at one per cycle while the
// token queue has room; unknown bytes are dropped, uppercase letters count as lowercase.
// Output channel rsp_*: one beat per equation, sent after the beat with req_tlast.
// rsp_tuser carries the status (ok, several variables, no variable, zero coefficient).
// After the last character, its token passes the queue and the accumulator's finish
// and hand-over states to the result unit; for a status other than ok that unit goes
// straight to its output state, for ok it first runs a binary gcd and then two
// shift-subtract divisions, numerator first. The gcd/divide unit handles one equation
// at a time; characters of the next equation keep flowing into the accumulator
// meanwhile and stall only at its last character until the unit is free. A result
// waits in its output register while rsp_tready is low; the input side keeps running
// until the queue fills. Reset (synchronous, active high) empties the queue and clears
// the accumulator's sums and flags.
module linear_equation_text_solver #(
   parameter int unsigned NUMBER_WIDTH = 32,
   parameter int unsigned QUEUE_DEPTH  = 4
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [7:0]                          req_tdata,   // char_code
   input  logic                                req_tlast,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // letter_index, is_negative, numerator, denominator, coefficient_total,
   // constant_total, zero fill
   output logic [letsv_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output logic [1:0]                          rsp_tuser    // status
);

   letsv_pkg::char_tok_type push_tok, pop_tok;
   letsv_pkg::job_type      job;
   logic                    push, queue_full, pop, pop_valid;
   logic                    job_valid, job_ready;
   logic [4:0]              letter;
   logic                    is_negative;
   logic [31:0]             numerator, denominator, coef_total, konst_total;

   letsv_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .queue_full (queue_full),
      .push       (push),
      .push_tok   (push_tok)
   );

   letsv_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_tok  (push_tok),
      .full      (queue_full),
      .pop       (pop),
      .pop_valid (pop_valid),
      .pop_tok   (pop_tok)
   );

   letsv_back #(
      .NUMBER_WIDTH (NUMBER_WIDTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .tok_valid (pop_valid),
      .tok       (pop_tok),
      .pop       (pop),
      .job_valid (job_valid),
      .job       (job),
      .job_ready (job_ready)
   );

   letsv_solve u_solve (
      .clock       (clock),
      .reset       (reset),
      .job_valid   (job_valid),
      .job         (job),
      .job_ready   (job_ready),
      .rsp_valid   (rsp_tvalid),
      .rsp_ready   (rsp_tready),
      .status      (rsp_tuser),
      .letter      (letter),
      .is_negative (is_negative),
      .numerator   (numerator),
      .denominator (denominator),
      .coef_total  (coef_total),
      .konst_total (konst_total)
   );

   assign rsp_tdata = {2'b00, konst_total, coef_total, denominator, numerator,
                       is_negative, letter};

endmodule

/* rtl/letsv_checker.sv */
// Port-level checks on the solver's result channel, bound to the top level.
`include "linear_equation_text_solver_assert.svh"

module letsv_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [letsv_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic [1:0]                       rsp_tuser
);

   logic [letsv_pkg::RSP_DATA_W+1:0] rsp_beat;
   logic [4:0]                       rsp_letter;
   logic                             rsp_neg;
   logic [31:0]                      rsp_numer, rsp_denom;
   logic                             rsp_stall, rsp_fail, rsp_novar, rsp_unit;

   assign rsp_beat   = {rsp_tuser, rsp_tdata};
   assign rsp_letter = rsp_tdata[4:0];
   assign rsp_neg    = rsp_tdata[5];
   assign rsp_numer  = rsp_tdata[37:6];
   assign rsp_denom  = rsp_tdata[69:38];
   assign rsp_stall  = rsp_tvalid && !rsp_tready;
   assign rsp_fail   = rsp_tvalid && rsp_tuser != letsv_pkg::STATUS_OK;
   assign rsp_novar  = rsp_tvalid && (rsp_tuser == letsv_pkg::STATUS_SEVERAL ||
                                      rsp_tuser == letsv_pkg::STATUS_NO_VAR);
   assign rsp_unit   = !rsp_neg && rsp_numer == 32'd0 && rsp_denom == 32'd1;

   // hold a stalled result beat
   `LETSV_ASSERT(a_rsp_hold, rsp_stall |=> rsp_tvalid && $stable(rsp_beat), "stalled beat changed")

   `LETSV_ASSERT(a_denom_nonzero, rsp_tvalid |-> rsp_denom != 32'd0, "zero denominator")

   `LETSV_ASSERT(a_fail_fraction, rsp_fail |-> rsp_unit, "fraction not cleared on failure")

   `LETSV_ASSERT(a_fail_letter, rsp_novar |-> rsp_letter == 5'd0, "letter not cleared")

   `LETSV_ASSERT_ALWAYS(a_reset_idle, reset |=> !rsp_tvalid, "result beat right after reset")

endmodule

bind linear_equation_text_solver letsv_checker u_checker (.*);

/* test/linear_equation_text_solver_checker.sv */
// Checker for the equation solver: tracks accepted characters, predicts each solution beat.
module linear_equation_text_solver_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   input  logic                             req_tready,
   input  logic [7:0]                       req_tdata,   // char_code
   input  logic                             req_tlast,
   input  logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // letter_index, is_negative, numerator, denominator, coefficient_total,
   // constant_total, zero fill
   input  logic [letsv_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic [1:0]                       rsp_tuser,   // status
   output int                               mismatch_count,
   output int                               outstanding
);

   typedef struct packed {
      logic [1:0]                     status;
      logic [letsv_pkg::LETTER_W-1:0] letter;
      logic                           negative;
      logic [letsv_pkg::SUM_W-1:0]    numerator;
      logic [letsv_pkg::SUM_W-1:0]    denominator;
      logic [letsv_pkg::SUM_W-1:0]    coef_total;
      logic [letsv_pkg::SUM_W-1:0]    const_total;
   } solution_type;

   solution_type expected_solutions[$];
   int errors = 0;

   // equation state, rebuilt after every final character
   logic                           in_run;
   logic [letsv_pkg::SUM_W-1:0]    number;
   logic                           past_equal;
   logic                           minus_pending;
   logic [letsv_pkg::LETTER_W-1:0] first_letter;
   logic                           have_letter;
   logic                           many_letters;
   logic [letsv_pkg::SUM_W-1:0]    coef_acc;
   logic [letsv_pkg::SUM_W-1:0]    const_acc;

   task automatic clear_equation();
      in_run        = 1'b0;
      number        = '0;
      past_equal    = 1'b0;
      minus_pending = 1'b0;
      first_letter  = '0;
      have_letter   = 1'b0;
      many_letters  = 1'b0;
      coef_acc      = '0;
      const_acc     = '0;
   endtask

   // negate for the side of '=', then for a pending minus, which is consumed
   task automatic place_term(inout logic [letsv_pkg::SUM_W-1:0] v, input logic flip);
      if (flip)
         v = -v;
      if (minus_pending) begin
         v = -v;
         minus_pending = 1'b0;
      end
   endtask

   task automatic fold_constant();
      logic [letsv_pkg::SUM_W-1:0] v;
      v = number;
      place_term(v, !past_equal);
      const_acc += v;
   endtask

   task automatic fold_letter(input logic [letsv_pkg::LETTER_W-1:0] idx);
      logic [letsv_pkg::SUM_W-1:0] v;
      v = (number == 0) ? 1 : number;
      place_term(v, past_equal);
      coef_acc += v;
      if (have_letter && first_letter != idx)
         many_letters = 1'b1;
      if (!have_letter) begin
         first_letter = idx;
         have_letter  = 1'b1;
      end
      number = '0;
      in_run = 1'b0;
   endtask

   task automatic digest_char(input logic [7:0] c);
      logic [7:0] delta;
      if (c >= "0" && c <= "9") begin
         delta  = c - "0";
         number = in_run ? number * 10 + delta : {24'd0, delta};
         in_run = 1'b1;
      end else if (c >= "a" && c <= "z") begin
         delta = c - "a";
         fold_letter(delta[letsv_pkg::LETTER_W-1:0]);
      end else if (c >= "A" && c <= "Z") begin
         delta = c - "A";
         fold_letter(delta[letsv_pkg::LETTER_W-1:0]);
      end else if (c == "+" || c == "-" || c == "*" || c == "/" || c == "%" ||
                   c == "^" || c == "=" || c == "(" || c == ")") begin
         if (number != 0)
            fold_constant();
         number = '0;
         in_run = 1'b0;
         if (c == "=")
            past_equal = 1'b1;
         if (c == "-")
            minus_pending = 1'b1;
      end else if (c == 8'h00 || c == " " || (c >= 8'h09 && c <= 8'h0D)) begin
         in_run = 1'b0;
      end
   endtask

   function automatic logic [letsv_pkg::SUM_W-1:0] common_divisor(
      input logic [letsv_pkg::SUM_W-1:0] a,
      input logic [letsv_pkg::SUM_W-1:0] b);
      logic [letsv_pkg::SUM_W-1:0] t;
      while (a != 0) begin
         t = b % a;
         b = a;
         a = t;
      end
      return b;
   endfunction

   task automatic close_equation(output solution_type s);
      logic                        cneg;
      logic                        vneg;
      logic [letsv_pkg::SUM_W-1:0] ca;
      logic [letsv_pkg::SUM_W-1:0] va;
      logic [letsv_pkg::SUM_W-1:0] g;
      if (number != 0)
         fold_constant();
      s.status      = letsv_pkg::STATUS_OK;
      s.letter      = '0;
      s.negative    = 1'b0;
      s.numerator   = '0;
      s.denominator = 1;
      s.coef_total  = coef_acc;
      s.const_total = const_acc;
      if (many_letters) begin
         s.status = letsv_pkg::STATUS_SEVERAL;
      end else if (!have_letter) begin
         s.status = letsv_pkg::STATUS_NO_VAR;
      end else if (coef_acc == 0) begin
         s.status = letsv_pkg::STATUS_ZERO_COEF;
         s.letter = first_letter;
      end else begin
         cneg          = const_acc[letsv_pkg::SUM_W-1];
         vneg          = coef_acc[letsv_pkg::SUM_W-1];
         ca            = cneg ? -const_acc : const_acc;
         va            = vneg ? -coef_acc : coef_acc;
         g             = common_divisor(ca, va);
         s.letter      = first_letter;
         s.negative    = cneg ^ vneg;
         s.numerator   = ca / g;
         s.denominator = va / g;
      end
      clear_equation();
   endtask

   always @(posedge clock) begin : watch
      solution_type want;
      solution_type got;
      if (reset) begin
         clear_equation();
         expected_solutions.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.status      = rsp_tuser;
            got.letter      = rsp_tdata[4:0];
            got.negative    = rsp_tdata[5];
            got.numerator   = rsp_tdata[37:6];
            got.denominator = rsp_tdata[69:38];
            got.coef_total  = rsp_tdata[101:70];
            got.const_total = rsp_tdata[133:102];
            if (expected_solutions.size() == 0) begin
               errors++;
               if (errors <= 10)
                  $display("%0t: solution beat with none pending: status %0d letter %0d",
                           $realtime, got.status, got.letter);
            end else begin
               want = expected_solutions.pop_front();
               if (got.status !== want.status || got.letter !== want.letter ||
                   got.negative !== want.negative || got.numerator !== want.numerator ||
                   got.denominator !== want.denominator ||
                   got.coef_total !== want.coef_total ||
                   got.const_total !== want.const_total) begin
                  errors++;
                  if (errors <= 10) begin
                     $display("%0t: solution mismatch", $realtime);
                     $display("   expected status %0d letter %0d neg %0b %0d/%0d coef %0d const %0d",
                              want.status, want.letter, want.negative, want.numerator,
                              want.denominator, $signed(want.coef_total),
                              $signed(want.const_total));
                     $display("   actual   status %0d letter %0d neg %0b %0d/%0d coef %0d const %0d",
                              got.status, got.letter, got.negative, got.numerator,
                              got.denominator, $signed(got.coef_total),
                              $signed(got.const_total));
                  end
               end
            end
         end
         if (req_tvalid && req_tready) begin
            digest_char(req_tdata);
            if (req_tlast) begin
               close_equation(want);
               expected_solutions.insert(expected_solutions.size(), want);
            end
         end
      end
      mismatch_count <= errors;
      outstanding    <= expected_solutions.size();
   end

endmodule

/* test/linear_equation_text_solver_test.sv */
// Top of the equation solver test: clock, reset, character stimulus, result drain, verdict.
module linear_equation_text_solver_test;

   localparam int TEXT_ITEMS      = 1250;
   localparam int QUIET_LIMIT     = 5000;
   localparam int TAIL_CYCLES     = 300;
   localparam int HOLD_OFF_CYCLES = 600;
   localparam int HOLD_OFF_BEAT   = 25;

   typedef struct packed {
      logic [7:0] code;
      logic       last;
   } char_beat_type;

   logic                             clock;
   logic                             reset;
   logic                             req_tvalid;
   logic                             req_tready;
   logic [7:0]                       req_tdata;
   logic                             req_tlast;
   logic                             rsp_tvalid;
   logic                             rsp_tready;
   logic [letsv_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic [1:0]                       rsp_tuser;
   int                               mismatch_count;
   int                               outstanding;
   int                               quiet_cycles = 0;

   char_beat_type text_q[$];

   linear_equation_text_solver u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   linear_equation_text_solver_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tlast      (req_tlast),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .mismatch_count (mismatch_count),
      .outstanding    (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   task automatic add_char(input logic [7:0] c, input logic last);
      char_beat_type b;
      b.code = c;
      b.last = last;
      text_q.insert(text_q.size(), b);
   endtask

   task automatic add_text(input string s, input logic ends);
      for (int i = 0; i < s.len(); i++)
         add_char(s[i], ends && i == s.len() - 1);
   endtask

   task automatic add_number();
      int digits;
      digits = ($urandom_range(0, 15) == 0) ? $urandom_range(8, 14) : $urandom_range(1, 3);
      repeat (digits)
         add_char(8'("0" + $urandom_range(0, 9)), 1'b0);
   endtask

   task automatic add_letter(input int idx);
      logic [7:0] c;
      c = 8'("a" + idx);
      if ($urandom_range(0, 3) == 0)
         c = c - 8'h20;
      add_char(c, 1'b0);
   endtask

   task automatic add_noise();
      string ops;
      ops = "*/%^()";
      case ($urandom_range(0, 3))
         0: add_char(" ", 1'b0);
         1: add_char(8'($urandom_range(9, 13)), 1'b0);
         2: add_char(8'($urandom_range(0, 255)), 1'b0);
         default: add_char(ops[$urandom_range(0, 5)], 1'b0);
      endcase
   endtask

   task automatic add_term(input int var_idx);
      int sign_pick;
      int letter_idx;
      sign_pick  = $urandom_range(0, 9);
      letter_idx = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 25) : var_idx;
      if (sign_pick <= 2)
         add_char("+", 1'b0);
      else if (sign_pick <= 5)
         add_char("-", 1'b0);
      else if (sign_pick == 6)
         add_text("--", 1'b0);
      if ($urandom_range(0, 9) == 0)
         add_noise();
      case ($urandom_range(0, 2))
         0: add_number();
         1: begin
            add_number();
            if ($urandom_range(0, 5) == 0)
               add_noise();
            add_letter(letter_idx);
         end
         default: add_letter(letter_idx);
      endcase
   endtask

   task automatic add_equation();
      int pick;
      int var_idx;
      pick    = $urandom_range(0, 15);
      var_idx = $urandom_range(0, 25);
      if (pick == 0) begin
         // garbage line
         repeat ($urandom_range(1, 10))
            add_char(8'($urandom_range(0, 255)), 1'b0);
      end else begin
         repeat ($urandom_range(1, 3))
            add_term(var_idx);
         if (pick != 1)
            add_char("=", 1'b0);
         repeat ($urandom_range(0, 3))
            add_term(var_idx);
         if ($urandom_range(0, 7) == 0)
            add_noise();
      end
      text_q[text_q.size() - 1].last = 1'b1;
   endtask

   // watchdog: count cycles with no beat on either channel
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // receiver: random stalls, calm stretches, and one long hold-off
   initial begin : drain
      int  stall;
      int  beats;
      bit  calm;
      beats = 0;
      calm  = 1'b0;
      rsp_tready <= 1'b0;
      @(posedge clock);
      while (reset)
         @(posedge clock);
      forever begin
         if ($urandom_range(0, 29) == 0)
            calm = !calm;
         stall = calm ? 0 : $urandom_range(0, 17);
         if (beats == HOLD_OFF_BEAT)
            stall = HOLD_OFF_CYCLES;
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         beats++;
      end
   end

   initial begin : stimulus
      int gap;
      bit calm;
      calm       = 1'b0;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tlast  <= 1'b0;

      // minus zero with an uppercase variable
      add_text("-X=0", 1'b1);
      // unknown byte inside a digit run, NUL as the final character
      add_char("1", 1'b0);
      add_char(8'hFF, 1'b0);
      add_text("2y=", 1'b0);
      add_char(8'h00, 1'b1);
      // two variables
      add_text("x=y", 1'b1);
      // no variable, repeated minus
      add_text("7--2", 1'b1);
      // space keeps the coefficient, sum cancels to zero
      add_text("3 z-3z", 1'b1);
      while (text_q.size() < TEXT_ITEMS)
         add_equation();

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (text_q[i]) begin
         if ($urandom_range(0, 39) == 0)
            calm = !calm;
         gap = calm ? 0 : $urandom_range(0, 17);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         req_tdata  <= text_q[i].code;
         req_tlast  <= text_q[i].last;
         req_tvalid <= 1'b1;
         do @(posedge clock); while (!req_tready);
      end
      req_tvalid <= 1'b0;

      @(posedge clock);
      while (outstanding != 0)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

/* linear_equation_text_solver.f */
+incdir+rtl
rtl/letsv_pkg.sv
rtl/letsv_front.sv
rtl/letsv_fifo.sv
rtl/letsv_back.sv
rtl/letsv_solve.sv
rtl/linear_equation_text_solver.sv
rtl/letsv_checker.sv
test/linear_equation_text_solver_checker.sv
test/linear_equation_text_solver_test.sv
